// ----- src/fbpa_pkg.sv -----
// Package for the fixed block pool allocator: field widths, codes and defaults.
// Used by the channel interfaces and by the top level; depends on nothing.
package fbpa_pkg;

    // Payload field widths, fixed by the item formats.
    localparam int KIND_W        = 1;
    localparam int FREE_IDX_W    = 8;
    localparam int STATUS_W      = 2;
    localparam int BLK_IDX_W     = 8;
    localparam int ADDR_W        = 32;
    localparam int PEAK_W        = 9;

    // Configuration port.
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int BSIZE_W       = 16;
    localparam int COUNT_W       = 9;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTANCE_COUNT = 2'd2;

    // Register reset values.
    localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = 32'd0;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 16'd4;
    localparam logic [COUNT_W-1:0] INST_COUNT_RST = 9'd256;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    // Default pool depth.
    localparam int POOL_BLOCKS_DEF = 256;

endpackage

// ----- src/fbpa_req_if.sv -----
// Request channel of the fixed block pool allocator: valid/ready plus request fields.
// Depends on fbpa_pkg for the field widths.
interface fbpa_req_if;
    import fbpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [FREE_IDX_W-1:0] free_index;

    modport source (output valid, output kind, output free_index, input ready);
    modport sink   (input valid, input kind, input free_index, output ready);
endinterface

// ----- src/fbpa_rsp_if.sv -----
// Result channel of the fixed block pool allocator: valid/ready plus result fields.
// Depends on fbpa_pkg for the field widths.
interface fbpa_rsp_if;
    import fbpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [BLK_IDX_W-1:0] block_index;
    logic [ADDR_W-1:0]    block_address;
    logic [PEAK_W-1:0]    peak_count;

    modport source (output valid, output status, output block_index,
                    output block_address, output peak_count, input ready);
    modport sink   (input valid, input status, input block_index,
                    input block_address, input peak_count, output ready);
endinterface

// ----- src/fixed_block_pool_allocator.sv -----
// A result is registered in the EXEC state that follows an accepted request item, or later
// when the previous result is still waiting in the result register.
// A new item is taken only in the idle state, once the previous item is through; the
// registered read of the next-link memory must finish before the new list head is known.
// The result register lets a new item in while the previous result waits.
// Reset (synchronous, active low) empties the free list, clears the bump counter and
// loads the register defaults; the next-link memory is not cleared.
module fixed_block_pool_allocator #(
    parameter int POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    fbpa_req_if.sink                            i_req,
    fbpa_rsp_if.source                          o_rsp
);
    import fbpa_pkg::*;

    // Block index width, head width (one more to code the empty list) and compare width.
    localparam int IW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int HW = IW + 1;
    localparam int CW = (HW > COUNT_W) ? HW : COUNT_W;
    localparam int PW = IW + BSIZE_W;
    localparam logic [HW-1:0] HEAD_EMPTY = HW'(POOL_BLOCKS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Configuration registers.
    logic [ADDR_W-1:0]  r_pool_base;
    logic [BSIZE_W-1:0] r_block_size;
    logic [COUNT_W-1:0] r_inst_count;

    // Control state.
    logic          r_state, n_state;
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_used, n_used;

    // Latched request.
    logic [KIND_W-1:0]     r_kind;
    logic [FREE_IDX_W-1:0] r_fidx;

    // Next-link memory and its registered read data.
    logic [HW-1:0] r_link_mem [POOL_BLOCKS];
    logic [HW-1:0] r_rd_link;
    logic          link_we;
    logic [IW-1:0] link_waddr;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [BLK_IDX_W-1:0] r_blk_idx, n_blk_idx;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [PEAK_W-1:0]    r_peak, n_peak;

    logic          req_acc;
    logic          done;
    logic [CW-1:0] limit;
    logic [IW-1:0] blk;
    logic          given;
    logic [PW-1:0] prod;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign done        = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    // Usable pool size: the configured count capped at the pool depth.
    assign limit = (CW'(r_inst_count) < CW'(POOL_BLOCKS)) ? CW'(r_inst_count)
                                                           : CW'(POOL_BLOCKS);

    // Block address of the chosen block.
    assign prod = PW'(blk) * PW'(r_block_size);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= POOL_BASE_RST;
            r_block_size <= BLOCK_SIZE_RST;
            r_inst_count <= INST_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POOL_BASE:      r_pool_base  <= i_cfg_data;
                CFG_BLOCK_SIZE:     r_block_size <= i_cfg_data[BSIZE_W-1:0];
                CFG_INSTANCE_COUNT: r_inst_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind <= i_req.kind;
            r_fidx <= i_req.free_index;
        end
    end

    // Next-link memory: read the link of the current head every cycle, write on a free.
    always_ff @(posedge i_clk) begin
        r_rd_link <= r_link_mem[r_head[IW-1:0]];
        if (link_we) begin
            r_link_mem[link_waddr] <= r_head;
        end
    end

    // Allocate and free decisions, taken when the result register can take the item.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_blk_idx   = r_blk_idx;
        n_addr      = r_addr;
        n_peak      = r_peak;
        link_we     = 1'b0;
        link_waddr  = IW'(r_fidx);
        blk         = '0;
        given       = 1'b0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    n_state  = ST_IDLE;
                    n_status = ST_OK;
                    if (r_kind == KIND_ALLOC) begin
                        if (r_head < HEAD_EMPTY) begin
                            // Pop the head of the free list.
                            blk    = r_head[IW-1:0];
                            given  = 1'b1;
                            n_head = r_rd_link;
                        end else if (CW'(r_used) < limit) begin
                            // Take the next never-used block.
                            blk    = r_used[IW-1:0];
                            given  = 1'b1;
                            n_used = r_used + HW'(1);
                        end else begin
                            n_status = ST_EXHAUSTED;
                        end
                    end else begin
                        if (CW'(r_fidx) < limit) begin
                            // Push the freed block onto the list head.
                            link_we = 1'b1;
                            n_head  = HW'(r_fidx);
                        end else begin
                            n_status = ST_BAD_INDEX;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_blk_idx   = given ? BLK_IDX_W'(blk) : '0;
                    n_addr      = given ? (r_pool_base + ADDR_W'(prod)) : '0;
                    n_peak      = PEAK_W'(n_used);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= HEAD_EMPTY;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_blk_idx <= n_blk_idx;
        r_addr    <= n_addr;
        r_peak    <= n_peak;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.block_index   = r_blk_idx;
    assign o_rsp.block_address = r_addr;
    assign o_rsp.peak_count    = r_peak;

    // The list head is a valid block or the empty mark.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= HEAD_EMPTY)
        else $error("free list head out of range");

    // The bump counter never passes the pool depth.
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= HW'(POOL_BLOCKS))
        else $error("bump counter out of range");

    // An accepted item moves the block to the EXEC state, where it takes no new request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while an item is in progress");

    // A failed request never carries a block address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.block_address == '0))
        else $error("failed request carries an address");

endmodule
